// ===== design/afs_pkg.sv =====
package afs_pkg;

    localparam int unsigned HDR_BYTES = 6;
    localparam int unsigned LEN_W = 13;
    localparam logic [LEN_W-1:0] MIN_LEN = 13'd7;
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [3:0] SYNC_NIBBLE = 4'hF;

    // Command queue between the parser and the emitter.
    localparam int unsigned QDEPTH = 8;
    localparam int unsigned QAW = $clog2(QDEPTH);
    localparam int unsigned QCW = $clog2(QDEPTH + 1);

    typedef enum logic {
        CMD_HEADER = 1'b0,
        CMD_BODY   = 1'b1
    } cmd_kind_t;

    // A header command carries all six held bytes; a body command uses data[0] only.
    typedef struct packed {
        cmd_kind_t                    kind;
        logic [HDR_BYTES-1:0][7:0]    data;
        logic                         last;
        logic [LEN_W-1:0]             len;
    } cmd_t;

endpackage

// ===== design/afs_parse.sv =====
module afs_parse (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic [7:0]                in_byte,
    output logic                      cmd_push,
    output afs_pkg::cmd_t             cmd
);

    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_BODY   = 2'd2
    } mode_t;

    typedef struct packed {
        logic                                 in_hdr;
        logic [7:0]                           prev;
        logic [2:0]                           cnt;
        logic [afs_pkg::HDR_BYTES-1:0][7:0]   hold;
    } scan_t;

    mode_t                                mode_reg, mode_next;
    logic [7:0]                           prev_reg, prev_next;
    logic [afs_pkg::LEN_W-1:0]            count_reg, count_next;
    logic [afs_pkg::LEN_W-1:0]            len_reg, len_next;
    logic [afs_pkg::HDR_BYTES-1:0][7:0]   hold_reg, hold_next;

    // One byte through the hunt and header-fill logic, without header completion.
    function automatic scan_t scan_byte(scan_t s, logic [7:0] b);
        scan_t r;
        r = s;
        if (s.in_hdr) begin
            r.hold[s.cnt] = b;
            r.cnt = s.cnt + 3'd1;
        end
        else if (s.prev == afs_pkg::SYNC_BYTE && b[7:4] == afs_pkg::SYNC_NIBBLE) begin
            r.hold[0] = afs_pkg::SYNC_BYTE;
            r.hold[1] = b;
            r.cnt = 3'd2;
            r.in_hdr = 1'b1;
        end
        else begin
            r.prev = b;
        end
        return r;
    endfunction

    always_comb
    begin
        logic [afs_pkg::HDR_BYTES-1:0][7:0] hdr;
        logic [afs_pkg::LEN_W-1:0]          hdr_len;
        logic [afs_pkg::LEN_W-1:0]          body_count;
        logic                               body_last;
        scan_t                              st;

        mode_next  = mode_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        len_next   = len_reg;
        hold_next  = hold_reg;
        cmd_push   = 1'b0;
        cmd        = '0;

        hdr = hold_reg;
        hdr[afs_pkg::HDR_BYTES-1] = in_byte;
        hdr_len = {hold_reg[3][1:0], hold_reg[4], in_byte[7:5]};
        body_count = count_reg + 13'd1;
        body_last = (body_count >= len_reg);
        st = '0;

        if (in_fire) begin
            case (mode_reg)
                MODE_BODY:
                begin
                    cmd_push     = 1'b1;
                    cmd.kind     = afs_pkg::CMD_BODY;
                    cmd.data[0]  = in_byte;
                    cmd.last     = body_last;
                    cmd.len      = len_reg;
                    count_next   = body_count;
                    if (body_last) begin
                        mode_next  = MODE_HUNT;
                        prev_next  = 8'd0;
                        count_next = '0;
                    end
                end
                MODE_HEADER:
                begin
                    if (count_reg >= 13'(afs_pkg::HDR_BYTES)) begin
                        mode_next  = MODE_HUNT;
                        prev_next  = 8'd0;
                        count_next = '0;
                    end
                    else if (count_reg == 13'(afs_pkg::HDR_BYTES - 1)) begin
                        hold_next = hdr;
                        if (hdr_len >= afs_pkg::MIN_LEN) begin
                            cmd_push   = 1'b1;
                            cmd.kind   = afs_pkg::CMD_HEADER;
                            cmd.data   = hdr;
                            cmd.last   = 1'b0;
                            cmd.len    = hdr_len;
                            len_next   = hdr_len;
                            count_next = 13'(afs_pkg::HDR_BYTES);
                            mode_next  = MODE_BODY;
                        end
                        else begin
                            // False sync: rescan the five bytes after the rejected sync.
                            st.in_hdr = 1'b0;
                            st.prev   = 8'd0;
                            st.cnt    = 3'd0;
                            st.hold   = hdr;
                            for (int i = 1; i < afs_pkg::HDR_BYTES; i++) begin
                                st = scan_byte(st, hdr[i]);
                            end
                            mode_next  = st.in_hdr ? MODE_HEADER : MODE_HUNT;
                            prev_next  = st.prev;
                            count_next = 13'(st.cnt);
                            hold_next  = st.hold;
                        end
                    end
                    else begin
                        hold_next[count_reg[2:0]] = in_byte;
                        count_next = count_reg + 13'd1;
                    end
                end
                default:
                begin
                    if (prev_reg == afs_pkg::SYNC_BYTE && in_byte[7:4] == afs_pkg::SYNC_NIBBLE)
                    begin
                        hold_next[0] = afs_pkg::SYNC_BYTE;
                        hold_next[1] = in_byte;
                        count_next   = 13'd2;
                        mode_next    = MODE_HEADER;
                    end
                    else begin
                        prev_next = in_byte;
                        mode_next = MODE_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_HUNT;
            prev_reg  <= 8'd0;
            count_reg <= '0;
            len_reg   <= '0;
        end
        else begin
            mode_reg  <= mode_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

// ===== design/afs_cmd_fifo.sv =====
module afs_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  afs_pkg::cmd_t    wr_data,
    output logic             full,
    input  logic             rd_en,
    output afs_pkg::cmd_t    rd_data,
    output logic             empty
);

    afs_pkg::cmd_t              entry_reg [afs_pkg::QDEPTH];
    logic [afs_pkg::QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [afs_pkg::QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [afs_pkg::QCW-1:0]    fill_reg, fill_next;
    logic                       do_wr;
    logic                       do_rd;

    assign full    = (fill_reg == afs_pkg::QCW'(afs_pkg::QDEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/afs_emit.sv =====
module afs_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  afs_pkg::cmd_t               cmd,
    input  logic                        cmd_valid,
    output logic                        cmd_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  frame_byte,
    output logic                        first_of_frame,
    output logic                        last_of_frame,
    output logic [afs_pkg::LEN_W-1:0]   frame_length
);

    logic                        out_valid_reg, out_valid_next;
    logic [2:0]                  idx_reg, idx_next;
    logic [7:0]                  byte_reg;
    logic                        first_reg;
    logic                        last_reg;
    logic [afs_pkg::LEN_W-1:0]   len_reg;
    logic                        load;
    logic                        is_hdr;

    assign is_hdr = (cmd.kind == afs_pkg::CMD_HEADER);
    assign load   = cmd_valid && (!out_valid_reg || pop);

    always_comb
    begin
        idx_next = idx_reg;
        cmd_pop  = 1'b0;
        if (load) begin
            if (!is_hdr) begin
                cmd_pop = 1'b1;
            end
            else if (idx_reg == 3'(afs_pkg::HDR_BYTES - 1)) begin
                cmd_pop  = 1'b1;
                idx_next = 3'd0;
            end
            else begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (load) begin
            out_valid_next = 1'b1;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg  <= is_hdr ? cmd.data[idx_reg] : cmd.data[0];
            first_reg <= is_hdr && (idx_reg == 3'd0);
            last_reg  <= !is_hdr && cmd.last;
            len_reg   <= cmd.len;
        end
    end

    assign empty          = !out_valid_reg;
    assign frame_byte     = byte_reg;
    assign first_of_frame = first_reg;
    assign last_of_frame  = last_reg;
    assign frame_length   = len_reg;

endmodule

// ===== design/adts_frame_splitter.sv =====
// Channel   Handshake          Payload
// input     push / full        stream_byte
// result    empty / pop        frame_byte, first_of_frame, last_of_frame, frame_length
//
// One byte is taken every cycle while the command queue has room.
// The parser turns each byte into at most one command; a header command is
// played out by the emitter as six items, a body byte as one.
// Each item is held in the command queue and then in the emitter's output register.
// The eight-entry command queue absorbs the header bursts, so full rises only
// when pop is held low. Reset is immediate; there is no clearing pass.
module adts_frame_splitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  stream_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  frame_byte,
    output logic                        first_of_frame,
    output logic                        last_of_frame,
    output logic [afs_pkg::LEN_W-1:0]   frame_length
);

    afs_pkg::cmd_t   front_cmd;
    afs_pkg::cmd_t   head_cmd;
    logic            front_push;
    logic            head_empty;
    logic            head_pop;
    logic            in_fire;

    assign in_fire = push && !full;

    afs_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_byte  (stream_byte),
        .cmd_push (front_push),
        .cmd      (front_cmd)
    );

    afs_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (head_pop),
        .rd_data (head_cmd),
        .empty   (head_empty)
    );

    afs_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (head_cmd),
        .cmd_valid      (!head_empty),
        .cmd_pop        (head_pop),
        .empty          (empty),
        .pop            (pop),
        .frame_byte     (frame_byte),
        .first_of_frame (first_of_frame),
        .last_of_frame  (last_of_frame),
        .frame_length   (frame_length)
    );

endmodule
